/* hdl/hhl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hhl_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int PREFIX_LEN  = 5;
  localparam int KEY_LEN     = 6;
  localparam int MIN_LEN_W   = 11;
  localparam int PAT_DEPTH   = 8;
  localparam int PAT_IDX_W   = $clog2(PAT_DEPTH);

  typedef logic [7:0]             byte_t;
  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [MIN_LEN_W-1:0]   min_len_t;

  localparam min_len_t MIN_LEN_RESET = min_len_t'(16);

  // "GET /"
  localparam byte_t PREFIX_PAT [PAT_DEPTH] = '{
    8'h47, 8'h45, 8'h54, 8'h20, 8'h2f, 8'h00, 8'h00, 8'h00
  };

  // "Host: "
  localparam byte_t KEY_PAT [PAT_DEPTH] = '{
    8'h48, 8'h6f, 8'h73, 8'h74, 8'h3a, 8'h20, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    RSN_FOUND     = 3'd0,
    RSN_NOT_ESTAB = 3'd1,
    RSN_NO_NAT    = 3'd2,
    RSN_BAD_HDR   = 3'd3,
    RSN_SHORT     = 3'd4,
    RSN_NO_GET    = 3'd5,
    RSN_NO_HOST   = 3'd6
  } reason_e;

endpackage

`default_nettype wire

/* hdl/hhl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hhl_in_if;
  import hhl_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_byte;
  logic  last_byte;
  len_t  payload_length;
  logic  established_outbound;
  logic  nat_active;
  logic  header_complete;
  logic  push_flag;
  logic  ack_flag;

  modport source (
    output valid, data_byte, first_byte, last_byte, payload_length,
           established_outbound, nat_active, header_complete, push_flag, ack_flag,
    input  ready
  );

  modport sink (
    input  valid, data_byte, first_byte, last_byte, payload_length,
           established_outbound, nat_active, header_complete, push_flag, ack_flag,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/hhl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hhl_out_if;
  import hhl_pkg::*;

  logic    valid;
  logic    ready;
  logic    hand_to_rewrite;
  len_t    host_key_end;
  reason_e reason;

  modport source (
    output valid, hand_to_rewrite, host_key_end, reason,
    input  ready
  );

  modport sink (
    input  valid, hand_to_rewrite, host_key_end, reason,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/hhl_match_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One key character: holds "the key so far ends at the last searched byte".
module hhl_match_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hhl_pkg::byte_t byte_i,
  input  wire hhl_pkg::byte_t pat_i,
  input  wire logic          link_i,
  input  wire logic          step_i,
  input  wire logic          restart_i,
  input  wire logic          flush_i,
  output logic               hit_o,
  output logic               match_o
);
  import hhl_pkg::*;

  logic match_d, match_q;

  assign hit_o = step_i & link_i & (byte_i == pat_i);

  always_comb begin
    if (flush_i) begin
      match_d = 1'b0;
    end else if (step_i) begin
      match_d = hit_o;
    end else if (restart_i) begin
      match_d = 1'b0;
    end else begin
      match_d = match_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;
endmodule

`default_nettype wire

/* hdl/http_get_host_header_locator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   data_byte, first/last_byte, payload_length, qualifiers
// out_o    out  valid/ready   hand_to_rewrite, host_key_end, reason
// cfg      in   cfg_we_i      cfg_wdata_i = min_payload_len
//
// One byte per cycle unless stalled; the verdict shows the cycle after the last byte.
// The key search is a row of KEY_LEN match cells, each passing its match bit on.
// Reset clears all packet state and loads min_payload_len with 16.
// Input stalls only while a verdict waits in the output register and out_o.ready is low.
module http_get_host_header_locator (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  hhl_in_if.sink                 in_i,
  hhl_out_if.source              out_o,
  input  wire logic              cfg_we_i,
  input  wire hhl_pkg::min_len_t cfg_wdata_i
);
  import hhl_pkg::*;

  localparam int LEN_EXT_W = LENGTH_BITS + 1;
  localparam len_t IDX_MAX = '1;

  min_len_t min_len_q;

  len_t    byte_index_d, byte_index_q;
  len_t    saved_length_d, saved_length_q;
  reason_e gate_reason_d, gate_reason_q;
  logic    prefix_ok_d, prefix_ok_q;
  logic    key_found_d, key_found_q;
  len_t    found_offset_d, found_offset_q;

  logic    out_valid_q;
  logic    hand_q;
  len_t    offset_q;
  reason_e reason_q;

  logic    accept, restart;
  len_t    cur_idx, cur_len, cur_off;
  reason_e cur_gate;
  logic    cur_ok, cur_found;
  logic    in_range, in_window, step, found_now;
  logic [LEN_EXT_W-1:0] window_end;
  reason_e verdict;

  logic [KEY_LEN-1:0] cell_hit, cell_match, cell_link;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign restart    = accept & in_i.first_byte;

  always_comb begin
    if (!in_i.established_outbound) begin
      cur_gate = RSN_NOT_ESTAB;
    end else if (!in_i.nat_active) begin
      cur_gate = RSN_NO_NAT;
    end else if (!in_i.header_complete || !(in_i.push_flag | in_i.ack_flag)) begin
      cur_gate = RSN_BAD_HDR;
    end else begin
      cur_gate = RSN_FOUND;
    end
    if (!in_i.first_byte) begin
      cur_gate = gate_reason_q;
    end
  end

  assign cur_idx   = in_i.first_byte ? '0 : byte_index_q;
  assign cur_len   = in_i.first_byte ? in_i.payload_length : saved_length_q;
  assign cur_ok    = in_i.first_byte ? 1'b1 : prefix_ok_q;
  assign cur_found = in_i.first_byte ? 1'b0 : key_found_q;
  assign cur_off   = in_i.first_byte ? '0 : found_offset_q;

  assign in_range   = cur_idx < cur_len;
  assign window_end = LEN_EXT_W'(cur_idx) + LEN_EXT_W'(KEY_LEN + PREFIX_LEN);
  assign in_window  = (cur_idx >= len_t'(PREFIX_LEN + 1)) &&
                      (window_end <= LEN_EXT_W'(cur_len));
  assign step       = accept & in_range & in_window & ~cur_found;

  for (genvar k = 0; k < KEY_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_link[k] = 1'b1;
    end else begin : g_body
      assign cell_link[k] = cell_match[k-1] & ~in_i.first_byte;
    end

    hhl_match_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .byte_i    (in_i.data_byte),
      .pat_i     (KEY_PAT[k]),
      .link_i    (cell_link[k]),
      .step_i    (step),
      .restart_i (restart),
      .flush_i   (found_now),
      .hit_o     (cell_hit[k]),
      .match_o   (cell_match[k])
    );
  end

  assign found_now = cell_hit[KEY_LEN-1];

  always_comb begin
    byte_index_d   = cur_idx;
    saved_length_d = cur_len;
    gate_reason_d  = cur_gate;
    prefix_ok_d    = cur_ok;
    key_found_d    = cur_found | found_now;
    found_offset_d = found_now ? cur_idx : cur_off;
    if (in_range) begin
      if ((cur_idx < len_t'(PREFIX_LEN)) &&
          (in_i.data_byte != PREFIX_PAT[cur_idx[PAT_IDX_W-1:0]])) begin
        prefix_ok_d = 1'b0;
      end
      if (cur_idx != IDX_MAX) begin
        byte_index_d = cur_idx + len_t'(1);
      end
    end
  end

  // Verdict from the state as it stands after this byte.
  always_comb begin
    if (gate_reason_d != RSN_FOUND) begin
      verdict = gate_reason_d;
    end else if ((saved_length_d == '0) || (saved_length_d < len_t'(min_len_q))) begin
      verdict = RSN_SHORT;
    end else if (!prefix_ok_d || (byte_index_d < len_t'(PREFIX_LEN))) begin
      verdict = RSN_NO_GET;
    end else if (!key_found_d) begin
      verdict = RSN_NO_HOST;
    end else begin
      verdict = RSN_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q      <= MIN_LEN_RESET;
      byte_index_q   <= '0;
      saved_length_q <= '0;
      gate_reason_q  <= RSN_FOUND;
      prefix_ok_q    <= 1'b1;
      key_found_q    <= 1'b0;
      found_offset_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        byte_index_q   <= byte_index_d;
        saved_length_q <= saved_length_d;
        gate_reason_q  <= gate_reason_d;
        prefix_ok_q    <= prefix_ok_d;
        key_found_q    <= key_found_d;
        found_offset_q <= found_offset_d;
      end
      // Hold the verdict until its transfer completes.
      if (accept && in_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last_byte) begin
      hand_q   <= (verdict == RSN_FOUND);
      offset_q <= (verdict == RSN_FOUND) ? found_offset_d : '0;
      reason_q <= verdict;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.hand_to_rewrite = hand_q;
  assign out_o.host_key_end    = offset_q;
  assign out_o.reason          = reason_q;
endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hhl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    byte_t      data;
    logic       first;
    logic       last;
    len_t       len;
    logic [4:0] quals;  // established, nat, header, psh, ack
  } payload_item_t;

  typedef struct {
    logic    hand;
    len_t    offset;
    reason_e reason;
  } verdict_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  min_len_t cfg_wdata_i;

  hhl_in_if  in_if ();
  hhl_out_if out_if ();

  http_get_host_header_locator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  payload_item_t tx_items[$];
  verdict_t      expected_verdicts[$];

  // Locator state as seen by the checker
  min_len_t   min_len = MIN_LEN_RESET;
  len_t       pkt_idx = '0;
  len_t       pkt_len = '0;
  len_t       hit_off = '0;
  reason_e    pkt_gate = RSN_FOUND;
  logic [3:0] pfx_pos = '0;
  logic [2:0] key_pos = '0;
  logic       key_hit = 1'b0;

  int          mismatches;
  int          fed_items;
  int          planned_verdicts;
  int          in_xfers;
  int          cycle_count;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  int          holds_done;
  int          pat_left;
  logic [15:0] stall_pat = 16'hFFFF;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic track_payload(input payload_item_t it);
    verdict_t v;
    if (it.first) begin
      pkt_idx = '0;
      pkt_len = it.len;
      if (!it.quals[4]) pkt_gate = RSN_NOT_ESTAB;
      else if (!it.quals[3]) pkt_gate = RSN_NO_NAT;
      else if (!it.quals[2] || it.quals[1:0] == 2'b00) pkt_gate = RSN_BAD_HDR;
      else pkt_gate = RSN_FOUND;
      pfx_pos = '0;
      key_pos = '0;
      key_hit = 1'b0;
      hit_off = '0;
    end
    if (pkt_idx < pkt_len) begin
      if (pkt_idx < PREFIX_LEN && pfx_pos == pkt_idx && it.data == PREFIX_PAT[pkt_idx[2:0]])
        pfx_pos = pfx_pos + 1'b1;
      if (!key_hit && pkt_idx > PREFIX_LEN &&
          int'(pkt_idx) + KEY_LEN + PREFIX_LEN <= int'(pkt_len)) begin
        // restart on a miss, then recheck the same byte against the key head
        if (it.data != KEY_PAT[key_pos]) key_pos = '0;
        if (it.data == KEY_PAT[key_pos]) begin
          if (key_pos == KEY_LEN - 1) begin
            key_hit = 1'b1;
            hit_off = pkt_idx;
            key_pos = '0;
          end else begin
            key_pos = key_pos + 1'b1;
          end
        end
      end
      if (pkt_idx != '1) pkt_idx = pkt_idx + 1'b1;
    end
    if (it.last) begin
      if (pkt_gate != RSN_FOUND) v.reason = pkt_gate;
      else if (pkt_len == 0 || pkt_len < min_len) v.reason = RSN_SHORT;
      else if (pfx_pos != PREFIX_LEN) v.reason = RSN_NO_GET;
      else if (!key_hit) v.reason = RSN_NO_HOST;
      else v.reason = RSN_FOUND;
      v.hand = (v.reason == RSN_FOUND);
      v.offset = v.hand ? hit_off : '0;
      expected_verdicts.push_back(v);
    end
  endtask

  function automatic byte_t filler();
    case ($urandom_range(0, 3))
      0: return KEY_PAT[$urandom_range(0, KEY_LEN - 1)];
      1: return PREFIX_PAT[$urandom_range(0, PREFIX_LEN - 1)];
      default: return byte_t'($urandom);
    endcase
  endfunction

  task automatic add_packet(input byte_t body[$], input len_t claimed,
                            input logic [4:0] quals, input bit with_first, input bit with_last);
    payload_item_t it;
    foreach (body[k]) begin
      it.data = body[k];
      it.first = with_first && k == 0;
      it.last = with_last && k == body.size() - 1;
      // qualifiers only count on the first item; scramble them elsewhere
      it.len = it.first ? claimed : len_t'($urandom);
      it.quals = it.first ? quals : 5'($urandom);
      tx_items.push_back(it);
      if (k < claimed) fed_items++;
    end
    if (with_last) planned_verdicts++;
  endtask

  task automatic place_key(ref byte_t body[$], input int fpos);
    int start;
    start = fpos - KEY_LEN + 1;
    if (start >= 0 && fpos < body.size())
      for (int k = 0; k < KEY_LEN; k++) body[start + k] = KEY_PAT[k];
  endtask

  task automatic queue_request(input bit with_last);
    byte_t      body[$];
    int         plen;
    int         fpos;
    int         start;
    int         depth;
    len_t       claimed;
    logic [4:0] quals;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 120) : $urandom_range(12, 48);
    for (int k = 0; k < plen; k++) body.push_back(k < PREFIX_LEN ? PREFIX_PAT[k] : filler());
    if ($urandom_range(0, 5) == 0) body[$urandom_range(0, PREFIX_LEN - 1)] = byte_t'($urandom);
    case ($urandom_range(0, 5))
      0: fpos = $urandom_range(PREFIX_LEN + KEY_LEN, plen - 1);
      1: fpos = plen - KEY_LEN - PREFIX_LEN;      // last spot inside the window
      2: fpos = plen - KEY_LEN - PREFIX_LEN + 1;  // key tail falls outside the window
      3: fpos = PREFIX_LEN + KEY_LEN - 1;         // key head sits before the window
      4: fpos = -1;
      default: begin
        // partial key right before the real one
        fpos = $urandom_range(PREFIX_LEN + KEY_LEN + 5, plen - 1);
        depth = $urandom_range(1, KEY_LEN - 1);
        start = fpos - KEY_LEN + 1 - depth;
        if (start > PREFIX_LEN && fpos < plen)
          for (int j = 0; j < depth; j++) body[start + j] = KEY_PAT[j];
      end
    endcase
    place_key(body, fpos);
    if (fpos >= 0 && $urandom_range(0, 3) == 0) place_key(body, fpos + KEY_LEN);
    claimed = len_t'(plen);
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 4)) body.push_back(byte_t'($urandom));
      1: claimed = len_t'($urandom_range(plen + 1, 65535));
      default: ;
    endcase
    if (!with_last) body = body[0:$urandom_range(0, plen - 2)];
    quals = ($urandom_range(0, 7) == 0) ? 5'($urandom) : {3'b111, 2'($urandom_range(1, 3))};
    add_packet(body, claimed, quals, 1'b1, with_last);
  endtask

  task automatic queue_noise(input bit with_first);
    byte_t body[$];
    repeat ($urandom_range(1, 8)) body.push_back(byte_t'($urandom));
    add_packet(body, len_t'($urandom), 5'($urandom), with_first, 1'b1);
  endtask

  task automatic queue_tiny();
    byte_t body[$];
    int    n;
    n = $urandom_range(0, PREFIX_LEN + 1);
    for (int k = 0; k < (n == 0 ? 1 : n); k++)
      body.push_back(($urandom_range(0, 3) == 0 || k >= PREFIX_LEN) ?
                     byte_t'($urandom) : PREFIX_PAT[k]);
    add_packet(body, len_t'(n), 5'b11111, 1'b1, 1'b1);
  endtask

  task automatic run_phase(input int quota, input bit closing);
    int stop_at;
    stop_at = fed_items + quota;
    while (fed_items < stop_at ||
           (closing && (fed_items < 600 || planned_verdicts < 60))) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_request(1'b1);
        6: queue_noise(1'b1);
        7: queue_tiny();
        8: begin
          queue_request(1'b0);
          queue_request(1'b1);
        end
        default: queue_noise(1'b0);
      endcase
    end
  endtask

  task automatic wait_drain();
    while (tx_items.size() != 0 || in_if.valid || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_min_len(input min_len_t value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_len = value;
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    payload_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0 || tx_items.size() == 0) begin
        in_if.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        it = tx_items.pop_front();
        in_if.valid <= 1'b1;
        in_if.data_byte <= it.data;
        in_if.first_byte <= it.first;
        in_if.last_byte <= it.last;
        in_if.payload_length <= it.len;
        in_if.established_outbound <= it.quals[4];
        in_if.nat_active <= it.quals[3];
        in_if.header_complete <= it.quals[2];
        in_if.push_flag <= it.quals[1];
        in_if.ack_flag <= it.quals[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    payload_item_t seen;
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen.data = in_if.data_byte;
      seen.first = in_if.first_byte;
      seen.last = in_if.last_byte;
      seen.len = in_if.payload_length;
      seen.quals = {in_if.established_outbound, in_if.nat_active, in_if.header_complete,
                    in_if.push_flag, in_if.ack_flag};
      track_payload(seen);
      in_xfers <= in_xfers + 1;
    end
  end

  // Long receiver hold-offs so the input side backs up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && in_xfers >= 120 + 300 * holds_done) begin
      hold_left <= 250;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: rotate a stall pattern, pick a fresh one now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && stall_pat[0];
      if (pat_left == 0) begin
        pat_left <= $urandom_range(16, 64);
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'hFFFF;
          1: stall_pat <= 16'($urandom);
          2: stall_pat <= 16'($urandom | $urandom);
          default: stall_pat <= 16'($urandom & $urandom);
        endcase
      end else begin
        pat_left <= pat_left - 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        note_mismatch($sformatf("verdict with none pending: hand %0b offset %0d reason %0d",
                                out_if.hand_to_rewrite, out_if.host_key_end, out_if.reason));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.hand_to_rewrite !== want.hand || out_if.host_key_end !== want.offset ||
            out_if.reason !== want.reason)
          note_mismatch($sformatf(
            "expected hand %0b offset %0d reason %0d, got hand %0b offset %0d reason %0d",
            want.hand, want.offset, want.reason,
            out_if.hand_to_rewrite, out_if.host_key_end, out_if.reason));
      end
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    byte_t pl[$];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte = 1'b0;
    in_if.payload_length = '0;
    in_if.established_outbound = 1'b0;
    in_if.nat_active = 1'b0;
    in_if.header_complete = 1'b0;
    in_if.push_flag = 1'b0;
    in_if.ack_flag = 1'b0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // last item with no first item: verdict from the reset state
    pl = {8'hA5};
    add_packet(pl, 16'd0, 5'b11111, 1'b0, 1'b1);
    // zero length
    pl = {8'hFF};
    add_packet(pl, 16'd0, 5'b11111, 1'b1, 1'b1);
    // gate priority: not established, then no NAT, then header and flags
    pl = {8'h00};
    add_packet(pl, 16'hFFFF, 5'b01111, 1'b1, 1'b1);
    pl = {PREFIX_PAT[0]};
    add_packet(pl, 16'hFFFF, 5'b10011, 1'b1, 1'b1);
    add_packet(pl, 16'hFFFF, 5'b11011, 1'b1, 1'b1);
    add_packet(pl, 16'hFFFF, 5'b11100, 1'b1, 1'b1);
    // long claimed length, prefix cut short
    add_packet(pl, 16'hFFFF, 5'b11101, 1'b1, 1'b1);
    // shortest hit: key ends on the last index of the window
    pl = {};
    for (int k = 0; k < PREFIX_LEN; k++) pl.push_back(PREFIX_PAT[k]);
    pl.push_back(8'h20);
    for (int k = 0; k < KEY_LEN; k++) pl.push_back(KEY_PAT[k]);
    repeat (10) pl.push_back(8'hFF);
    add_packet(pl, len_t'(pl.size()), 5'b11110, 1'b1, 1'b1);

    run_phase(150, 1'b0);
    wait_drain();
    set_min_len(min_len_t'(12));
    run_phase(150, 1'b0);
    wait_drain();
    set_min_len(min_len_t'(1500));
    run_phase(80, 1'b0);
    wait_drain();
    set_min_len(min_len_t'($urandom_range(17, 40)));
    run_phase(150, 1'b0);
    wait_drain();
    set_min_len(min_len_t'(PREFIX_LEN + 1 + KEY_LEN + PREFIX_LEN + KEY_LEN));
    run_phase(100, 1'b1);
    wait_drain();
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
